@@ design/ugb_pkg.sv @@
`default_nettype none

package ugb_pkg;

    // Default sizes of the stores
    localparam int MAX_CELLS_DEF    = 1024;
    localparam int SLOTS_DEF        = 16;
    localparam int MAX_REFS_DEF     = 16;
    localparam int MAX_ENTITIES_DEF = 1024;

    // Coordinate bits taken from each 16-bit input corner
    localparam int COORD_BITS = 16;
    localparam logic [15:0] CoordMask =
        (COORD_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << COORD_BITS) - 32'd1);

    localparam int CfgAddrBits = 4;

    typedef enum logic [1:0] {
        REG_CELL_SHIFT  = 2'd0,
        REG_GRID_WIDTH  = 2'd1,
        REG_GRID_HEIGHT = 2'd2
    } reg_index_t;

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_REMOVE = 1'b1
    } command_t;

    typedef enum logic [2:0] {
        STAT_MOVED      = 3'd0,
        STAT_UNCHANGED  = 3'd1,
        STAT_REMOVED    = 3'd2,
        STAT_NOT_PLACED = 3'd3,
        STAT_CELL_FULL  = 3'd4,
        STAT_TOO_LARGE  = 3'd5
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_DECIDE,
        S_CL_REF,
        S_CL_OCC,
        S_CL_LAST,
        S_CL_MOVE,
        S_SR_CNT,
        S_SR_REF,
        S_SR_CMP,
        S_CL_END,
        S_IN_CALC,
        S_IN_OCC,
        S_IN_END
    } state_t;

    // Grid size as used: zero acts as one, above 32 acts as 32
    function automatic logic [5:0] eff_dim(input logic [5:0] v);
        logic [5:0] r;
        if (v == 6'd0)
            r = 6'd1;
        else if (v > 6'd32)
            r = 6'd32;
        else
            r = v;
        return r;
    endfunction

    // World coordinate to cell, clamped to the last cell
    function automatic logic [4:0] to_cell(input logic [15:0] coord,
                                           input logic [3:0]  shift,
                                           input logic [5:0]  dim);
        logic [15:0] c;
        logic [5:0]  lim;
        logic [4:0]  r;
        c   = (coord & CoordMask) >> shift;
        lim = dim - 6'd1;
        if (c < {10'd0, lim})
            r = c[4:0];
        else
            r = lim[4:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/ugb_ram.sv @@
`default_nettype none

module ugb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/uniform_grid_broadphase.sv @@
`default_nettype none

// Uniform grid broadphase.
// Command channel: an item (command, entity_id, box corners) is taken
// when start is high and busy is low. Update places the entity in every
// grid cell its box covers; remove takes it out of all its cells.
// Result channel: done pulses for one cycle with status and cells_covered;
// the receiver cannot stall, so results are never held.
// Unchanged, rejected or unplaced items pass through DECODE and DECIDE
// and their result is registered. An update or remove walks the entity's old
// references: CL_REF, CL_OCC, CL_LAST and CL_MOVE per old cell (CL_MOVE
// left out if the cell is skipped), plus, when another entity is moved into
// the freed slot, SR_CNT and then SR_REF and SR_CMP per reference of that
// entity searched. Then IN_CALC and IN_OCC per new cell (IN_OCC left out
// if skipped). Each store has a single read port.
// One item at a time; busy stays high until its result is shown.
// Configuration is an APB-style port (shift at 0x0, width 0x4, height 0x8);
// the user must write it only while idle, the block does not enforce this.
// Reset: after rst_n rises, the occupancy and entity tables are swept
// to zero in the S_CLEAR state, with busy high.
module uniform_grid_broadphase #(
    parameter int MAX_CELLS      = ugb_pkg::MAX_CELLS_DEF,
    parameter int SLOTS_PER_CELL = ugb_pkg::SLOTS_DEF,
    parameter int MAX_REFS       = ugb_pkg::MAX_REFS_DEF,
    parameter int MAX_ENTITIES   = ugb_pkg::MAX_ENTITIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [ugb_pkg::CfgAddrBits-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        command,
    input  wire logic [9:0]  entity_id,
    input  wire logic [15:0] min_x,
    input  wire logic [15:0] min_y,
    input  wire logic [15:0] max_x,
    input  wire logic [15:0] max_y,
    output logic             done,
    output logic [2:0]       status,
    output logic [4:0]       cells_covered
);

    localparam int CW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int EW  = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
    localparam int SW  = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
    localparam int OW  = $clog2(SLOTS_PER_CELL + 1);
    localparam int RW  = $clog2(MAX_REFS + 1);
    localparam int SLOT_DEPTH = MAX_CELLS * SLOTS_PER_CELL;
    localparam int REF_DEPTH  = MAX_ENTITIES * MAX_REFS;
    localparam int SAW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int RAW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
    localparam int REFW  = CW + SW;
    localparam int INFOW = 1 + 20 + RW;
    localparam int SWEEP_N = (MAX_CELLS > MAX_ENTITIES) ? MAX_CELLS : MAX_ENTITIES;
    localparam int SWW = (SWEEP_N > 1) ? $clog2(SWEEP_N) : 1;

    // Configuration registers
    logic [3:0] shift_reg;
    logic [5:0] gwidth_reg;
    logic [5:0] gheight_reg;

    // Item registers
    logic        cmd_reg;
    logic [9:0]  eidx_reg;
    logic [15:0] minx_reg, miny_reg, maxx_reg, maxy_reg;

    ugb_pkg::state_t state_reg, state_next;

    logic [RW-1:0]  cnt_e_reg, cnt_e_next;
    logic [19:0]    span_e_reg, span_e_next;
    logic           placed_e_reg, placed_e_next;
    logic [4:0]     cx0_reg, cy0_reg, cx1_reg, cy1_reg;
    logic [4:0]     cx0_next, cy0_next, cx1_next, cy1_next;
    logic [RW-1:0]  k_reg, k_next;
    logic [CW-1:0]  rcell_reg, rcell_next;
    logic [SW-1:0]  rslot_reg, rslot_next;
    logic [OW-1:0]  occ_reg, occ_next;
    logic [EW-1:0]  moved_reg, moved_next;
    logic [RW-1:0]  mcnt_reg, mcnt_next;
    logic [RW-1:0]  j_reg, j_next;
    logic [4:0]     x_reg, x_next, y_reg, y_next;
    logic [RW-1:0]  n_reg, n_next;
    logic           full_reg, full_next;
    logic [CW-1:0]  c_reg, c_next;
    logic [SWW-1:0] sweep_reg;
    logic           done_reg, done_next;
    logic [2:0]     status_reg, status_next;
    logic [4:0]     cov_reg, cov_next;

    // Memory ports
    logic            occ_we;
    logic [CW-1:0]   occ_waddr, occ_raddr;
    logic [OW-1:0]   occ_wdata, occ_rdata;
    logic            slot_we;
    logic [SAW-1:0]  slot_waddr, slot_raddr;
    logic [EW-1:0]   slot_wdata, slot_rdata;
    logic            ref_we;
    logic [RAW-1:0]  ref_waddr, ref_raddr;
    logic [REFW-1:0] ref_wdata, ref_rdata;
    logic            info_we;
    logic [EW-1:0]   info_waddr, info_raddr;
    logic [INFOW-1:0] info_wdata, info_rdata;

    ugb_ram #(.WIDTH(OW), .DEPTH(MAX_CELLS)) u_occ (
        .clk(clk), .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
        .raddr(occ_raddr), .rdata(occ_rdata)
    );

    ugb_ram #(.WIDTH(EW), .DEPTH(SLOT_DEPTH)) u_slot (
        .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(slot_raddr), .rdata(slot_rdata)
    );

    ugb_ram #(.WIDTH(REFW), .DEPTH(REF_DEPTH)) u_ref (
        .clk(clk), .we(ref_we), .waddr(ref_waddr), .wdata(ref_wdata),
        .raddr(ref_raddr), .rdata(ref_rdata)
    );

    ugb_ram #(.WIDTH(INFOW), .DEPTH(MAX_ENTITIES)) u_info (
        .clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
        .raddr(info_raddr), .rdata(info_rdata)
    );

    // Shared decode terms
    logic          accept;
    logic          e_bad;
    logic [EW-1:0] e_w;
    logic [5:0]    gw, gh;
    logic [5:0]    nx, ny;
    logic [11:0]   span_cells;
    logic [19:0]   span_new;
    logic [10:0]   c_full;
    logic          ins_skip;
    logic          last_x, last_y;
    logic [CW-1:0] ref_cell;
    logic [SW-1:0] ref_slot;
    logic          cl_skip;
    logic          ref_done, sr_done;

    assign accept     = start && (state_reg == ugb_pkg::S_IDLE);
    assign e_bad      = (32'(eidx_reg) >= MAX_ENTITIES);
    assign e_w        = EW'(eidx_reg);
    assign gw         = ugb_pkg::eff_dim(gwidth_reg);
    assign gh         = ugb_pkg::eff_dim(gheight_reg);
    assign nx         = (cx1_reg >= cx0_reg) ? 6'(cx1_reg - cx0_reg) + 6'd1 : 6'd0;
    assign ny         = (cy1_reg >= cy0_reg) ? 6'(cy1_reg - cy0_reg) + 6'd1 : 6'd0;
    assign span_cells = 12'(nx) * 12'(ny);
    assign span_new   = {cy1_reg, cx1_reg, cy0_reg, cx0_reg};
    assign c_full     = 11'(y_reg) * 11'(gw) + 11'(x_reg);
    assign ins_skip   = (32'(c_full) >= MAX_CELLS) || (32'(n_reg) >= MAX_REFS);
    assign last_x     = (x_reg == cx1_reg);
    assign last_y     = (y_reg == cy1_reg);
    assign ref_cell   = ref_rdata[REFW-1:SW];
    assign ref_slot   = ref_rdata[SW-1:0];
    assign cl_skip    = (occ_rdata == '0) || (32'(rslot_reg) >= 32'(occ_rdata))
                        || (32'(occ_rdata) > SLOTS_PER_CELL);
    assign ref_done   = (k_reg == cnt_e_reg) || (32'(k_reg) >= MAX_REFS);
    assign sr_done    = (j_reg == mcnt_reg) || (32'(j_reg) >= MAX_REFS);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ugb_pkg::S_CLEAR:
                if (32'(sweep_reg) == SWEEP_N - 1)
                    state_next = ugb_pkg::S_IDLE;
            ugb_pkg::S_IDLE:
                if (start)
                    state_next = ugb_pkg::S_DECODE;
            ugb_pkg::S_DECODE:
                state_next = ugb_pkg::S_DECIDE;
            ugb_pkg::S_DECIDE:
            begin
                if (e_bad)
                    state_next = ugb_pkg::S_IDLE;
                else if (cmd_reg == ugb_pkg::CMD_REMOVE)
                    state_next = placed_e_reg ? ugb_pkg::S_CL_REF : ugb_pkg::S_IDLE;
                else if (placed_e_reg && span_e_reg == span_new)
                    state_next = ugb_pkg::S_IDLE;
                else if (32'(span_cells) > MAX_REFS)
                    state_next = ugb_pkg::S_IDLE;
                else
                    state_next = ugb_pkg::S_CL_REF;
            end
            ugb_pkg::S_CL_REF:
                state_next = ref_done ? ugb_pkg::S_CL_END : ugb_pkg::S_CL_OCC;
            ugb_pkg::S_CL_OCC:
                state_next = ugb_pkg::S_CL_LAST;
            ugb_pkg::S_CL_LAST:
                state_next = cl_skip ? ugb_pkg::S_CL_REF : ugb_pkg::S_CL_MOVE;
            ugb_pkg::S_CL_MOVE:
                if (32'(rslot_reg) != 32'(occ_reg) - 1)
                    state_next = ugb_pkg::S_SR_CNT;
                else
                    state_next = ugb_pkg::S_CL_REF;
            ugb_pkg::S_SR_CNT:
                state_next = ugb_pkg::S_SR_REF;
            ugb_pkg::S_SR_REF:
                state_next = sr_done ? ugb_pkg::S_CL_REF : ugb_pkg::S_SR_CMP;
            ugb_pkg::S_SR_CMP:
                state_next = (ref_cell == rcell_reg) ? ugb_pkg::S_CL_REF
                                                     : ugb_pkg::S_SR_REF;
            ugb_pkg::S_CL_END:
                if (cmd_reg == ugb_pkg::CMD_REMOVE)
                    state_next = ugb_pkg::S_IDLE;
                else if (nx == 6'd0 || ny == 6'd0)
                    state_next = ugb_pkg::S_IN_END;
                else
                    state_next = ugb_pkg::S_IN_CALC;
            ugb_pkg::S_IN_CALC:
                if (!ins_skip)
                    state_next = ugb_pkg::S_IN_OCC;
                else if (last_x && last_y)
                    state_next = ugb_pkg::S_IN_END;
            ugb_pkg::S_IN_OCC:
                state_next = (last_x && last_y) ? ugb_pkg::S_IN_END
                                                : ugb_pkg::S_IN_CALC;
            ugb_pkg::S_IN_END:
                state_next = ugb_pkg::S_IDLE;
            default:
                state_next = ugb_pkg::S_IDLE;
        endcase
    end

    // Datapath, memory ports and result
    always_comb
    begin
        cnt_e_next    = cnt_e_reg;
        span_e_next   = span_e_reg;
        placed_e_next = placed_e_reg;
        cx0_next      = cx0_reg;
        cy0_next      = cy0_reg;
        cx1_next      = cx1_reg;
        cy1_next      = cy1_reg;
        k_next        = k_reg;
        rcell_next    = rcell_reg;
        rslot_next    = rslot_reg;
        occ_next      = occ_reg;
        moved_next    = moved_reg;
        mcnt_next     = mcnt_reg;
        j_next        = j_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        n_next        = n_reg;
        full_next     = full_reg;
        c_next        = c_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        cov_next      = cov_reg;

        occ_we     = 1'b0;
        occ_waddr  = '0;
        occ_wdata  = '0;
        occ_raddr  = '0;
        slot_we    = 1'b0;
        slot_waddr = '0;
        slot_wdata = '0;
        slot_raddr = '0;
        ref_we     = 1'b0;
        ref_waddr  = '0;
        ref_wdata  = '0;
        ref_raddr  = '0;
        info_we    = 1'b0;
        info_waddr = '0;
        info_wdata = '0;
        info_raddr = '0;

        unique case (state_reg)
            ugb_pkg::S_CLEAR:
            begin
                occ_we     = (32'(sweep_reg) < MAX_CELLS);
                occ_waddr  = CW'(sweep_reg);
                info_we    = (32'(sweep_reg) < MAX_ENTITIES);
                info_waddr = EW'(sweep_reg);
            end
            ugb_pkg::S_IDLE:
                info_raddr = EW'(entity_id);
            ugb_pkg::S_DECODE:
            begin
                {placed_e_next, span_e_next, cnt_e_next} = info_rdata;
                cx0_next = ugb_pkg::to_cell(minx_reg, shift_reg, gw);
                cy0_next = ugb_pkg::to_cell(miny_reg, shift_reg, gh);
                cx1_next = ugb_pkg::to_cell((maxx_reg & ugb_pkg::CoordMask) == 16'd0
                               ? 16'd0 : (maxx_reg & ugb_pkg::CoordMask) - 16'd1,
                               shift_reg, gw);
                cy1_next = ugb_pkg::to_cell((maxy_reg & ugb_pkg::CoordMask) == 16'd0
                               ? 16'd0 : (maxy_reg & ugb_pkg::CoordMask) - 16'd1,
                               shift_reg, gh);
            end
            ugb_pkg::S_DECIDE:
            begin
                k_next = '0;
                if (e_bad)
                begin
                    done_next   = 1'b1;
                    status_next = ugb_pkg::STAT_NOT_PLACED;
                    cov_next    = 5'd0;
                end
                else if (cmd_reg == ugb_pkg::CMD_REMOVE)
                begin
                    if (!placed_e_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ugb_pkg::STAT_NOT_PLACED;
                        cov_next    = 5'd0;
                    end
                end
                else if (placed_e_reg && span_e_reg == span_new)
                begin
                    done_next   = 1'b1;
                    status_next = ugb_pkg::STAT_UNCHANGED;
                    cov_next    = 5'(cnt_e_reg);
                end
                else if (32'(span_cells) > MAX_REFS)
                begin
                    done_next   = 1'b1;
                    status_next = ugb_pkg::STAT_TOO_LARGE;
                    cov_next    = 5'(cnt_e_reg);
                end
            end
            // Walk the entity's old references
            ugb_pkg::S_CL_REF:
                ref_raddr = RAW'(32'(e_w) * MAX_REFS + 32'(k_reg));
            ugb_pkg::S_CL_OCC:
            begin
                rcell_next = ref_cell;
                rslot_next = ref_slot;
                occ_raddr  = ref_cell;
            end
            ugb_pkg::S_CL_LAST:
            begin
                occ_next   = occ_rdata;
                slot_raddr = SAW'(32'(rcell_reg) * SLOTS_PER_CELL
                                  + 32'(occ_rdata) - 1);
                if (cl_skip)
                    k_next = k_reg + RW'(1);
            end
            // Swap the last slot into the freed one
            ugb_pkg::S_CL_MOVE:
            begin
                moved_next = slot_rdata;
                slot_we    = 1'b1;
                slot_waddr = SAW'(32'(rcell_reg) * SLOTS_PER_CELL + 32'(rslot_reg));
                slot_wdata = slot_rdata;
                occ_we     = 1'b1;
                occ_waddr  = rcell_reg;
                occ_wdata  = occ_reg - OW'(1);
                info_raddr = slot_rdata;
                if (32'(rslot_reg) == 32'(occ_reg) - 1)
                    k_next = k_reg + RW'(1);
            end
            ugb_pkg::S_SR_CNT:
            begin
                mcnt_next = info_rdata[RW-1:0];
                j_next    = '0;
            end
            // Find the moved entity's reference to this cell
            ugb_pkg::S_SR_REF:
            begin
                ref_raddr = RAW'(32'(moved_reg) * MAX_REFS + 32'(j_reg));
                if (sr_done)
                    k_next = k_reg + RW'(1);
            end
            ugb_pkg::S_SR_CMP:
            begin
                if (ref_cell == rcell_reg)
                begin
                    ref_we    = 1'b1;
                    ref_waddr = RAW'(32'(moved_reg) * MAX_REFS + 32'(j_reg));
                    ref_wdata = {rcell_reg, rslot_reg};
                    k_next    = k_reg + RW'(1);
                end
                else
                begin
                    j_next = j_reg + RW'(1);
                end
            end
            ugb_pkg::S_CL_END:
            begin
                x_next    = cx0_reg;
                y_next    = cy0_reg;
                n_next    = '0;
                full_next = 1'b0;
                if (cmd_reg == ugb_pkg::CMD_REMOVE)
                begin
                    info_we     = 1'b1;
                    info_waddr  = e_w;
                    info_wdata  = {1'b0, span_e_reg, {RW{1'b0}}};
                    done_next   = 1'b1;
                    status_next = ugb_pkg::STAT_REMOVED;
                    cov_next    = 5'd0;
                end
            end
            // Insert into the new cells, row by row
            ugb_pkg::S_IN_CALC:
            begin
                c_next    = CW'(c_full);
                occ_raddr = CW'(c_full);
                if (ins_skip)
                begin
                    full_next = 1'b1;
                    if (last_x)
                    begin
                        x_next = cx0_reg;
                        y_next = y_reg + 5'd1;
                    end
                    else
                    begin
                        x_next = x_reg + 5'd1;
                    end
                end
            end
            ugb_pkg::S_IN_OCC:
            begin
                if (32'(occ_rdata) >= SLOTS_PER_CELL)
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    slot_we    = 1'b1;
                    slot_waddr = SAW'(32'(c_reg) * SLOTS_PER_CELL + 32'(occ_rdata));
                    slot_wdata = e_w;
                    ref_we     = 1'b1;
                    ref_waddr  = RAW'(32'(e_w) * MAX_REFS + 32'(n_reg));
                    ref_wdata  = {c_reg, SW'(occ_rdata)};
                    occ_we     = 1'b1;
                    occ_waddr  = c_reg;
                    occ_wdata  = occ_rdata + OW'(1);
                    n_next     = n_reg + RW'(1);
                end
                if (last_x)
                begin
                    x_next = cx0_reg;
                    y_next = y_reg + 5'd1;
                end
                else
                begin
                    x_next = x_reg + 5'd1;
                end
            end
            ugb_pkg::S_IN_END:
            begin
                info_we     = 1'b1;
                info_waddr  = e_w;
                info_wdata  = {1'b1, span_new, n_reg};
                done_next   = 1'b1;
                status_next = full_reg ? ugb_pkg::STAT_CELL_FULL : ugb_pkg::STAT_MOVED;
                cov_next    = 5'(n_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ugb_pkg::S_CLEAR;
            sweep_reg   <= '0;
            done_reg    <= 1'b0;
            shift_reg   <= 4'd5;
            gwidth_reg  <= 6'd32;
            gheight_reg <= 6'd32;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (state_reg == ugb_pkg::S_CLEAR)
                sweep_reg <= sweep_reg + SWW'(1);
            if (psel && penable && pwrite)
            begin
                case (paddr[3:2])
                    ugb_pkg::REG_CELL_SHIFT:  shift_reg   <= pwdata[3:0];
                    ugb_pkg::REG_GRID_WIDTH:  gwidth_reg  <= pwdata[5:0];
                    ugb_pkg::REG_GRID_HEIGHT: gheight_reg <= pwdata[5:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            eidx_reg <= entity_id;
            minx_reg <= min_x;
            miny_reg <= min_y;
            maxx_reg <= max_x;
            maxy_reg <= max_y;
        end
        cnt_e_reg    <= cnt_e_next;
        span_e_reg   <= span_e_next;
        placed_e_reg <= placed_e_next;
        cx0_reg      <= cx0_next;
        cy0_reg      <= cy0_next;
        cx1_reg      <= cx1_next;
        cy1_reg      <= cy1_next;
        k_reg        <= k_next;
        rcell_reg    <= rcell_next;
        rslot_reg    <= rslot_next;
        occ_reg      <= occ_next;
        moved_reg    <= moved_next;
        mcnt_reg     <= mcnt_next;
        j_reg        <= j_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        n_reg        <= n_next;
        full_reg     <= full_next;
        c_reg        <= c_next;
        status_reg   <= status_next;
        cov_reg      <= cov_next;
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[3:2])
            ugb_pkg::REG_CELL_SHIFT:  prdata = {28'd0, shift_reg};
            ugb_pkg::REG_GRID_WIDTH:  prdata = {26'd0, gwidth_reg};
            ugb_pkg::REG_GRID_HEIGHT: prdata = {26'd0, gheight_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    assign pready        = 1'b1;
    assign busy          = (state_reg != ugb_pkg::S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign cells_covered = cov_reg;

endmodule

`default_nettype wire

@@ design/ugb_checker.sv @@
`default_nettype none

module ugb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [2:0] status,
    input wire logic [4:0] cells_covered
);

    // An accepted item keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("item accepted but block not busy");

    // Each result is a single-cycle strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // Status codes stay in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status <= ugb_pkg::STAT_TOO_LARGE)
        else $error("status code out of range");

    // Removal and unplaced results report no cells
    a_removed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ugb_pkg::STAT_REMOVED || status == ugb_pkg::STAT_NOT_PLACED)
        |-> cells_covered == 5'd0)
        else $error("removed entity still covers cells");

endmodule

bind uniform_grid_broadphase ugb_checker u_ugb_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .done(done),
    .status(status),
    .cells_covered(cells_covered)
);

`default_nettype wire
